FILE: rtl/asbc_pkg.sv
// Package for the allocation-site byte counter: payload structs, request and
// status codes, hash constants and controller command/status types.
// No dependencies.
package asbc_pkg;

    localparam logic [63:0] HASH_MUL  = 64'h4372897893428797;
    localparam logic [63:0] HASH_SEED = 64'd7;
    localparam logic [47:0] COUNT_MAX = 48'hFFFF_FFFF_FFFF;
    localparam int          FRAME_NUM = 8;

    typedef enum logic
    {
        REQ_ALLOC = 1'b0,
        REQ_FREE  = 1'b1
    } req_kind_t;

    typedef enum logic [2:0]
    {
        ST_OK        = 3'd0,
        ST_REDIRECT  = 3'd1,
        ST_FULL      = 3'd2,
        ST_UNDERFLOW = 3'd3,
        ST_SATURATED = 3'd4
    } status_code_t;

    typedef struct packed
    {
        logic        req_type;
        logic [63:0] frame_0;
        logic [63:0] frame_1;
        logic [63:0] frame_2;
        logic [63:0] frame_3;
        logic [63:0] frame_4;
        logic [63:0] frame_5;
        logic [63:0] frame_6;
        logic [63:0] frame_7;
        logic [30:0] alloc_bytes;
        logic [11:0] free_slot;
    } in_item_t;

    typedef struct packed
    {
        logic [11:0] slot;
        logic [2:0]  status;
        logic [47:0] site_bytes;
        logic [12:0] sites_used;
    } out_item_t;

    // Controller to datapath commands.
    typedef struct packed
    {
        logic load;        // capture the accepted request
        logic hash_init;   // hash register to seed, frame counter to zero
        logic hash_step;   // one multiply-add step
        logic hash_end;    // replace zero hash, set probe position
        logic unk_load;    // switch to unknown site hash
        logic probe_rd;    // issue table read at probe position
        logic probe_next;  // advance probe position
        logic insert;      // write hash at probe position, bump occupancy
        logic cnt_rd;      // read count at chosen slot
        logic cnt_wr;      // compute and write back count, form result
        logic full;        // form a table-full result
        logic out_load;    // present the result
    } asbc_cmd_t;

    // Datapath to controller status.
    typedef struct packed
    {
        logic is_free;
        logic hash_done;
        logic mul_done;
        logic slot_empty;
        logic slot_match;
        logic sweep_done;
        logic over_half;
        logic over_70;
    } asbc_stat_t;

endpackage

FILE: rtl/allocation_site_byte_counter_core.sv
// Top level of the allocation-site byte counter.
// Depends on asbc_pkg, asbc_ctrl and asbc_datapath.
//
// Usage: requests enter on the in channel (in_valid / in_stall / in_data);
// one result per request leaves on the out channel (out_valid / out_stall /
// out_data). A transfer happens on a rising edge with valid high and stall
// low. Allocate requests hash HASHED_FRAMES frame words with a multiply-add
// step per frame; the 64-bit multiply is split into three 32x32 partial
// products, registered one after another before the add. Linear probing then
// reads the hash memory, one read state and one check state a probe, and the
// count update reads and then writes the count memory. A free request skips
// hashing and probing. One request is in flight at a time. After reset a
// clearing pass zeroes both memories, and in_stall stays high until it is
// done. A stalled result stays on out_data; the next request may be taken
// meanwhile, and its result waits until the result register has been freed.
module allocation_site_byte_counter_core
    import asbc_pkg::*;
#(
    parameter int TABLE_DEPTH   = 4096,
    parameter int HASHED_FRAMES = 8
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_stall,
    output out_item_t out_data
);

    asbc_cmd_t  cmd;
    asbc_stat_t stat;
    out_item_t  res;
    logic       ctrl_stall;
    logic       clr_done_reg;
    logic [$clog2(TABLE_DEPTH):0] clr_cnt_reg;
    logic       out_valid_reg;
    out_item_t  out_data_reg;

    // The clearing pass is timed here so that no request arrives before the
    // memories are zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg  <= '0;
            clr_done_reg <= 1'b0;
        end
        else if (!clr_done_reg)
        begin
            clr_cnt_reg <= clr_cnt_reg + ($clog2(TABLE_DEPTH) + 1)'(1);
            if (clr_cnt_reg == ($clog2(TABLE_DEPTH) + 1)'(TABLE_DEPTH))
            begin
                clr_done_reg <= 1'b1;
            end
        end
    end

    // The controller waits on the output register, and takes no request before the clearing pass is done.
    asbc_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid && clr_done_reg),
        .in_stall (ctrl_stall),
        .out_busy (out_valid_reg && out_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    asbc_datapath #(
        .TABLE_DEPTH   (TABLE_DEPTH),
        .HASHED_FRAMES (HASHED_FRAMES)
    ) u_dp
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (in_data),
        .cmd   (cmd),
        .stat  (stat),
        .res   (res)
    );

    assign in_stall = ctrl_stall || !clr_done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_data_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

FILE: rtl/asbc_ctrl.sv
// Controller state machine of the allocation-site byte counter.
// Depends on asbc_pkg; drives asbc_datapath through command structs.
module asbc_ctrl
    import asbc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       out_busy,
    input  asbc_stat_t stat,
    output asbc_cmd_t  cmd
);

    typedef enum logic [9:0]
    {
        S_IDLE  = 10'b00_0000_0001,
        S_MUL   = 10'b00_0000_0010,
        S_ADD   = 10'b00_0000_0100,
        S_HEND  = 10'b00_0000_1000,
        S_PRD   = 10'b00_0001_0000,
        S_PCHK  = 10'b00_0010_0000,
        S_CRD   = 10'b00_0100_0000,
        S_CWR   = 10'b00_1000_0000,
        S_OUT   = 10'b01_0000_0000,
        S_FULL  = 10'b10_0000_0000
    } state_t;

    state_t state_reg, state_next;
    logic   forced_reg, forced_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            forced_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            forced_reg <= forced_next;
        end
    end

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next  = state_reg;
        forced_next = forced_reg;
        cmd         = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load      = 1'b1;
                    cmd.hash_init = 1'b1;
                    forced_next   = 1'b0;
                    state_next    = S_MUL;
                end
            end
            S_MUL:
            begin
                if (stat.is_free)
                begin
                    state_next = S_CRD;
                end
                else if (stat.mul_done)
                begin
                    state_next = S_ADD;
                end
            end
            S_ADD:
            begin
                cmd.hash_step = 1'b1;
                state_next    = stat.hash_done ? S_HEND : S_MUL;
            end
            S_HEND:
            begin
                cmd.hash_end = 1'b1;
                state_next   = S_PRD;
            end
            S_PRD:
            begin
                cmd.probe_rd = 1'b1;
                state_next   = S_PCHK;
            end
            S_PCHK:
            begin
                if (stat.slot_empty)
                begin
                    if (stat.over_half && !forced_reg)
                    begin
                        cmd.unk_load = 1'b1;
                        forced_next  = 1'b1;
                        state_next   = S_PRD;
                    end
                    else if (stat.over_half && stat.over_70)
                    begin
                        state_next = S_FULL;
                    end
                    else
                    begin
                        cmd.insert = 1'b1;
                        state_next = S_CRD;
                    end
                end
                else if (stat.slot_match)
                begin
                    state_next = S_CRD;
                end
                else if (stat.sweep_done)
                begin
                    state_next = S_FULL;
                end
                else
                begin
                    cmd.probe_next = 1'b1;
                    state_next     = S_PRD;
                end
            end
            S_CRD:
            begin
                cmd.cnt_rd = 1'b1;
                state_next = S_CWR;
            end
            S_CWR:
            begin
                cmd.cnt_wr = 1'b1;
                state_next = S_OUT;
            end
            S_FULL:
            begin
                cmd.full   = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/asbc_datapath.sv
// Datapath of the allocation-site byte counter: hash unit, probe logic,
// hash and count memories, occupancy and result formation. Uses asbc_pkg.
module asbc_datapath
    import asbc_pkg::*;
#(
    parameter int TABLE_DEPTH   = 4096,
    parameter int HASHED_FRAMES = 8
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  in_item_t   req,
    input  asbc_cmd_t  cmd,
    output asbc_stat_t stat,
    output out_item_t  res
);

    // Hash of the unknown site (frame_0 = 1, the rest zero), worked out at elaboration.
    function automatic logic [63:0] unk_hash();
        logic [63:0] h;
        h = HASH_SEED;
        for (int i = 0; i < HASHED_FRAMES; i++)
        begin
            h = h * HASH_MUL + ((i == 0) ? 64'd1 : 64'd0);
        end
        unk_hash = (h == 64'd0) ? 64'd1 : h;
    endfunction

    localparam int AW  = $clog2(TABLE_DEPTH);
    localparam int OW  = $clog2(TABLE_DEPTH + 1);
    localparam int FW  = $clog2(FRAME_NUM);
    localparam logic [OW+3:0] HALF  = (OW + 4)'(TABLE_DEPTH / 2);
    localparam logic [OW+3:0] SEVEN = (OW + 4)'(TABLE_DEPTH * 7);
    localparam logic [FW:0]   LAST  = (FW + 1)'(HASHED_FRAMES - 1);
    localparam logic [63:0]   UNK_HASH = unk_hash();

    in_item_t    req_reg;
    logic [63:0] hash_reg;
    logic [FW:0] fidx_reg;
    logic [1:0]  mcnt_reg;
    logic [31:0] pp_reg [4];
    logic [AW-1:0] pos_reg;
    logic [AW:0]   nprobe_reg;
    logic [63:0] hrd_reg;
    logic [47:0] crd_reg;
    logic [OW-1:0] occ_reg;
    logic [OW-1:0] occ_next;
    logic [AW-1:0] clr_reg;
    logic          clr_busy_reg;
    logic          redir_reg;
    out_item_t     res_reg;

    logic [63:0] hash_mem [TABLE_DEPTH];
    logic [47:0] cnt_mem  [TABLE_DEPTH];

    logic [63:0] frame;
    logic [63:0] hnew;
    logic [AW-1:0] cslot;
    logic [48:0]   csum;

    always_comb
    begin
        case (fidx_reg[FW-1:0])
            3'd0:    frame = req_reg.frame_0;
            3'd1:    frame = req_reg.frame_1;
            3'd2:    frame = req_reg.frame_2;
            3'd3:    frame = req_reg.frame_3;
            3'd4:    frame = req_reg.frame_4;
            3'd5:    frame = req_reg.frame_5;
            3'd6:    frame = req_reg.frame_6;
            default: frame = req_reg.frame_7;
        endcase
    end

    // 64x64 low product from three 32x32 partial products, one per cycle.
    logic [63:0] lo_ll, lo_cross;
    assign lo_ll    = {pp_reg[1], pp_reg[0]};
    assign lo_cross = {pp_reg[2] + pp_reg[3], 32'd0};
    assign hnew     = lo_ll + lo_cross + frame;

    logic [31:0] ma, mb;
    logic [63:0] mprod;
    always_comb
    begin
        case (mcnt_reg)
            2'd0:    begin ma = hash_reg[31:0];  mb = HASH_MUL[31:0];  end
            2'd1:    begin ma = hash_reg[31:0];  mb = HASH_MUL[63:32]; end
            default: begin ma = hash_reg[63:32]; mb = HASH_MUL[31:0];  end
        endcase
    end
    assign mprod = ma * mb;

    assign cslot = (req_reg.req_type == REQ_FREE) ? req_reg.free_slot[AW-1:0] : pos_reg;
    assign csum  = {1'b0, crd_reg} + {18'd0, req_reg.alloc_bytes};

    logic [OW+3:0] occ_w;
    assign occ_w = {4'd0, occ_reg};

    always_comb
    begin
        stat.is_free    = (req_reg.req_type == REQ_FREE);
        stat.hash_done  = (fidx_reg == LAST);
        stat.mul_done   = (mcnt_reg == 2'd3);
        stat.slot_empty = (hrd_reg == 64'd0);
        stat.slot_match = (hrd_reg == hash_reg);
        stat.sweep_done = (nprobe_reg == (AW + 1)'(TABLE_DEPTH - 1));
        stat.over_half  = (occ_w > HALF);
        stat.over_70    = ((occ_w << 3) + (occ_w << 1) >= SEVEN);
    end

    assign occ_next = occ_reg + OW'(1);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg <= req;
        end
        if (cmd.hash_init || cmd.hash_step)
        begin
            mcnt_reg <= 2'd0;
        end
        else if (mcnt_reg != 2'd3)
        begin
            mcnt_reg <= mcnt_reg + 2'd1;
        end
        if (mcnt_reg != 2'd3)
        begin
            if (mcnt_reg == 2'd0)
            begin
                pp_reg[0] <= mprod[31:0];
                pp_reg[1] <= mprod[63:32];
            end
            else
            begin
                pp_reg[{1'b1, mcnt_reg == 2'd2}] <= mprod[31:0];
            end
        end
        if (cmd.hash_init)
        begin
            hash_reg <= HASH_SEED;
            fidx_reg <= '0;
        end
        else if (cmd.hash_step)
        begin
            hash_reg <= hnew;
            fidx_reg <= fidx_reg + (FW + 1)'(1);
        end
        else if (cmd.hash_end)
        begin
            // A zero hash is filed as one, and probing starts from there.
            if (hash_reg == 64'd0)
            begin
                hash_reg <= 64'd1;
                pos_reg  <= AW'(1);
            end
            else
            begin
                pos_reg  <= hash_reg[AW-1:0];
            end
            nprobe_reg <= '0;
        end
        else if (cmd.unk_load)
        begin
            hash_reg   <= UNK_HASH;
            pos_reg    <= UNK_HASH[AW-1:0];
            nprobe_reg <= '0;
        end
        if (cmd.probe_next)
        begin
            pos_reg    <= pos_reg + AW'(1);
            nprobe_reg <= nprobe_reg + (AW + 1)'(1);
        end
        if (cmd.probe_rd)
        begin
            hrd_reg <= hash_mem[pos_reg];
        end
        if (cmd.insert)
        begin
            hash_mem[pos_reg] <= hash_reg;
        end
        else if (clr_busy_reg)
        begin
            hash_mem[clr_reg] <= 64'd0;
        end
        if (cmd.cnt_rd)
        begin
            crd_reg <= cnt_mem[cslot];
        end
        if (cmd.cnt_wr)
        begin
            res_reg.slot       <= 12'(cslot);
            res_reg.sites_used <= 13'(occ_reg);
            if (req_reg.req_type == REQ_FREE)
            begin
                if (48'(req_reg.alloc_bytes) > crd_reg)
                begin
                    res_reg.status     <= ST_UNDERFLOW;
                    res_reg.site_bytes <= crd_reg;
                end
                else
                begin
                    res_reg.status     <= ST_OK;
                    res_reg.site_bytes <= crd_reg - 48'(req_reg.alloc_bytes);
                    cnt_mem[cslot]     <= crd_reg - 48'(req_reg.alloc_bytes);
                end
            end
            else if (csum[48])
            begin
                res_reg.status     <= ST_SATURATED;
                res_reg.site_bytes <= COUNT_MAX;
                cnt_mem[cslot]     <= COUNT_MAX;
            end
            else
            begin
                res_reg.status     <= redir_reg ? ST_REDIRECT : ST_OK;
                res_reg.site_bytes <= csum[47:0];
                cnt_mem[cslot]     <= csum[47:0];
            end
        end
        else if (clr_busy_reg)
        begin
            cnt_mem[clr_reg] <= 48'd0;
        end
        if (cmd.full)
        begin
            res_reg.slot       <= '0;
            res_reg.status     <= ST_FULL;
            res_reg.site_bytes <= '0;
            res_reg.sites_used <= 13'(occ_reg);
        end
    end

    // Occupancy, clearing pass and redirect flag, set when the controller switches to the unknown site.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg      <= '0;
            redir_reg    <= 1'b0;
            clr_reg      <= '0;
            clr_busy_reg <= 1'b1;
        end
        else
        begin
            if (cmd.insert)
            begin
                occ_reg <= occ_next;
            end
            if (cmd.load)
            begin
                redir_reg <= 1'b0;
            end
            else if (cmd.unk_load)
            begin
                redir_reg <= 1'b1;
            end
            if (clr_busy_reg)
            begin
                clr_reg <= clr_reg + AW'(1);
                if (clr_reg == AW'(TABLE_DEPTH - 1))
                begin
                    clr_busy_reg <= 1'b0;
                end
            end
        end
    end

    assign res = '{slot: res_reg.slot, status: res_reg.status,
                   site_bytes: res_reg.site_bytes, sites_used: res_reg.sites_used};

endmodule

FILE: tb/allocation_site_byte_counter_checker.sv
// Checker for the allocation-site byte counter: watches both channels, keeps its own copy
// of the site table and compares every result transfer with the predicted one.
// Depends on asbc_pkg.
module allocation_site_byte_counter_checker
    import asbc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      in_stall,
    input  in_item_t  in_data,
    input  logic      out_valid,
    input  logic      out_stall,
    input  out_item_t out_data,
    output int        errors,
    output int        pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH  = 4096;
    localparam int FRAMES = 8;

    logic [63:0] key_tbl [DEPTH];
    logic [47:0] bytes_tbl [DEPTH];
    int          sites_held;
    out_item_t   due_results[$];

    function automatic logic [63:0] site_key(in_item_t r);
        logic [63:0] fr [8];
        logic [63:0] h;
        fr = '{r.frame_0, r.frame_1, r.frame_2, r.frame_3,
               r.frame_4, r.frame_5, r.frame_6, r.frame_7};
        h = HASH_SEED;
        for (int i = 0; i < FRAMES; i++)
            h = h * HASH_MUL + fr[i];
        return (h == 64'd0) ? 64'd1 : h;
    endfunction

    // Finds or inserts the slot for a key; a new site past half occupancy is sent to the
    // unknown site instead. Returns -1 when no slot can be given.
    function automatic int claim_slot(logic [63:0] key, output bit redirected);
        in_item_t    unk;
        logic [63:0] k;
        int          pos;
        bit          forced;
        unk = '0;
        unk.frame_0 = 64'd1;
        k = key;
        forced = 0;
        redirected = 0;
        for (int pass = 0; pass < 2; pass++)
        begin
            pos = int'(k % DEPTH);
            for (int n = 0; n < DEPTH; n++)
            begin
                if (key_tbl[pos] == 64'd0)
                begin
                    if (sites_held > DEPTH / 2)
                    begin
                        if (forced)
                        begin
                            if (sites_held * 10 >= DEPTH * 7)
                                return -1;
                        end
                        else
                        begin
                            redirected = 1;
                            break;
                        end
                    end
                    key_tbl[pos] = k;
                    sites_held++;
                    return pos;
                end
                if (key_tbl[pos] == k)
                    return pos;
                pos = (pos + 1) % DEPTH;
            end
            if (!redirected || forced)
                return -1;
            forced = 1;
            k = site_key(unk);
        end
        return -1;
    endfunction

    function automatic out_item_t account_request(in_item_t r);
        out_item_t   res;
        int          s;
        bit          redir;
        logic [48:0] sum;
        res = '0;
        if (req_kind_t'(r.req_type) == REQ_ALLOC)
        begin
            s = claim_slot(site_key(r), redir);
            if (s < 0)
                res.status = ST_FULL;
            else
            begin
                sum = {1'b0, bytes_tbl[s]} + r.alloc_bytes;
                if (sum > {1'b0, COUNT_MAX})
                begin
                    bytes_tbl[s] = COUNT_MAX;
                    res.status = ST_SATURATED;
                end
                else
                begin
                    bytes_tbl[s] = sum[47:0];
                    res.status = redir ? ST_REDIRECT : ST_OK;
                end
                res.slot = s[11:0];
                res.site_bytes = bytes_tbl[s];
            end
        end
        else
        begin
            s = int'(r.free_slot) % DEPTH;
            if (48'(r.alloc_bytes) > bytes_tbl[s])
                res.status = ST_UNDERFLOW;
            else
                bytes_tbl[s] = bytes_tbl[s] - 48'(r.alloc_bytes);
            res.slot = s[11:0];
            res.site_bytes = bytes_tbl[s];
        end
        res.sites_used = sites_held[12:0];
        return res;
    endfunction

    assign pending = due_results.size();

    initial
    begin
        errors = 0;
        sites_held = 0;
        for (int i = 0; i < DEPTH; i++)
        begin
            key_tbl[i] = '0;
            bytes_tbl[i] = '0;
        end
    end

    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (due_results.size() == 0)
            begin
                $display("%0t: result transfer with none expected, actual %p", $realtime, out_data);
                errors++;
            end
            else
            begin
                want = due_results.pop_front();
                if (out_data.slot !== want.slot)
                begin
                    $display("%0t: slot expected %0d actual %0d", $realtime, want.slot, out_data.slot);
                    errors++;
                end
                if (out_data.status !== want.status)
                begin
                    $display("%0t: status expected %0d actual %0d",
                             $realtime, want.status, out_data.status);
                    errors++;
                end
                if (out_data.site_bytes !== want.site_bytes)
                begin
                    $display("%0t: site_bytes expected %0d actual %0d",
                             $realtime, want.site_bytes, out_data.site_bytes);
                    errors++;
                end
                if (out_data.sites_used !== want.sites_used)
                begin
                    $display("%0t: sites_used expected %0d actual %0d",
                             $realtime, want.sites_used, out_data.sites_used);
                    errors++;
                end
            end
        end
        if (rst_n && in_valid && !in_stall)
            due_results.push_back(account_request(in_data));
    end
endmodule

FILE: tb/allocation_site_byte_counter_core_test.sv
// Top of the allocation-site byte counter testbench: clock, reset, request stimulus,
// result-side stalling, watchdog and verdict.
// Depends on asbc_pkg, allocation_site_byte_counter_core and the checker module.
module allocation_site_byte_counter_core_test
    import asbc_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCH_LIMIT = 100000;
    localparam int HOLD_CYCLES = 400;
    localparam int POOL_SIZE   = 48;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    in_item_t  in_data;
    logic      out_valid;
    logic      out_stall;
    out_item_t out_data;
    int        errors;
    int        pending;

    // When calm is set neither side idles; hold_off asks the receiver for a long stall.
    bit        calm;
    bit        hold_off;
    in_item_t  site_pool [POOL_SIZE];

    allocation_site_byte_counter_core dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    allocation_site_byte_counter_checker checker_i
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .errors    (errors),
        .pending   (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Hash of the first n frames, used only to aim frees and to build a zero hash.
    function automatic logic [63:0] partial_key(in_item_t r, int n);
        logic [63:0] fr [8];
        logic [63:0] h;
        fr = '{r.frame_0, r.frame_1, r.frame_2, r.frame_3,
               r.frame_4, r.frame_5, r.frame_6, r.frame_7};
        h = HASH_SEED;
        for (int i = 0; i < n; i++)
            h = h * HASH_MUL + fr[i];
        return h;
    endfunction

    // A site with random frames; later frames are sometimes absent, as in short backtraces.
    function automatic in_item_t random_site();
        in_item_t r;
        int       depth;
        r = '0;
        depth = $urandom_range(1, 8);
        r.frame_0 = rand64();
        if (depth > 1) r.frame_1 = rand64();
        if (depth > 2) r.frame_2 = rand64();
        if (depth > 3) r.frame_3 = rand64();
        if (depth > 4) r.frame_4 = rand64();
        if (depth > 5) r.frame_5 = rand64();
        if (depth > 6) r.frame_6 = rand64();
        if (depth > 7) r.frame_7 = rand64();
        r.req_type = REQ_ALLOC;
        r.free_slot = 12'($urandom);
        return r;
    endfunction

    function automatic logic [30:0] random_bytes();
        if ($urandom_range(99) < 15)
            return 31'($urandom);
        return 31'($urandom_range(0, 4096));
    endfunction

    // Offers one request and returns once the transfer has taken place, at a falling edge.
    task automatic offer(in_item_t r);
        while (!calm && $urandom_range(99) < 11)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= r;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
    endtask

    task automatic alloc_at(in_item_t site, logic [30:0] bytes);
        in_item_t r;
        r = site;
        r.req_type = REQ_ALLOC;
        r.alloc_bytes = bytes;
        offer(r);
    endtask

    task automatic free_at(logic [11:0] slot, logic [30:0] bytes);
        in_item_t r;
        r = random_site();
        r.req_type = REQ_FREE;
        r.free_slot = slot;
        r.alloc_bytes = bytes;
        offer(r);
    endtask

    task automatic random_request();
        int       pick;
        in_item_t site;
        pick = $urandom_range(99);
        site = site_pool[$urandom_range(POOL_SIZE - 1)];
        if (pick < 65)
            alloc_at(site, random_bytes());
        else if (pick < 75)
            alloc_at(random_site(), random_bytes());
        else if (pick < 92)
            free_at(12'(partial_key(site, 8)), 31'($urandom_range(0, 3000)));
        else
            free_at(12'($urandom), random_bytes());
    endtask

    // Result side: random stalls, or one long hold-off when asked for.
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_off = 0;
            end
            out_stall <= !calm && ($urandom_range(99) < 11);
        end
    end

    // Watchdog: counts cycles without any transfer on either channel.
    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCH_LIMIT)
            begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    initial
    begin
        in_item_t    site;
        in_item_t    unk;
        logic [63:0] h;
        logic [11:0] aim;
        calm = 0;
        hold_off = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        for (int i = 0; i < POOL_SIZE; i++)
            site_pool[i] = random_site();
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part: field extremes, both request kinds, underflow, the unknown site and a zero hash.
        site = '0;
        alloc_at(site, 31'd0);
        alloc_at(site, 31'h7FFF_FFFF);
        alloc_at(site, 31'd5);
        site = '1;
        alloc_at(site, 31'h7FFF_FFFF);
        aim = 12'(partial_key(site, 8));
        free_at(aim, 31'h7FFF_FFFF);
        free_at(aim, 31'd1);
        free_at(aim, 31'h7FFF_FFFE);
        free_at(aim, 31'd0);
        free_at(aim, 31'd1);
        // The unknown site may also be named directly.
        unk = '0;
        unk.frame_0 = 64'd1;
        alloc_at(unk, 31'd100);
        // A site whose hash comes out as zero is filed under hash one.
        site = random_site();
        h = partial_key(site, 7) * HASH_MUL;
        site.frame_7 = 64'd0 - h;
        alloc_at(site, 31'd77);
        alloc_at(site, 31'd3);
        free_at(12'd1, 31'd80);
        free_at(12'd1, 31'd10);
        free_at(12'd4095, 31'd0);
        free_at(12'd0, 31'h7FFF_FFFF);
        free_at(12'd0, 31'd0);

        // Random part, with a calm stretch, a long receiver hold-off and a drained pause.
        for (int i = 0; i < 980; i++)
        begin
            calm = (i >= 300 && i < 450);
            if (i == 500)
                hold_off = 1;
            if (i == 700)
            begin
                in_valid <= 1'b0;
                wait (pending == 0);
                @(negedge clk);
            end
            random_request();
        end
        in_valid <= 1'b0;

        wait (pending == 0);
        repeat (100) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
